FILE: sv/qlu_pkg.sv
// Shared widths, constants and arithmetic helpers of the quaternion local update.
`timescale 1ns / 1ps
package qlu_pkg;

  localparam int FRAC_BITS_DEF = 30;
  localparam int DQ_BITS       = 30;
  localparam int WORD_W        = 32;
  localparam int SQ_W          = 64;
  localparam int RT_W          = SQ_W / 2;
  localparam int M_W           = 31;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SQ_W-1:0]   dword_t;

  // Full signed product of two words.
  function automatic dword_t smul(input word_t a, input word_t b);
    logic signed [SQ_W-1:0] ea;
    logic signed [SQ_W-1:0] eb;
    ea = $signed(a);
    eb = $signed(b);
    smul = dword_t'(ea * eb);
  endfunction

endpackage

FILE: sv/qlu_ifs.sv
// Channel interfaces of the quaternion local update: request, result and configuration.
`timescale 1ns / 1ps
interface qlu_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] quat_w;
  logic [31:0] quat_x;
  logic [31:0] quat_y;
  logic [31:0] quat_z;
  logic [31:0] incr_a;
  logic [31:0] incr_b;
  logic [31:0] incr_c;
  modport source(output valid, quat_w, quat_x, quat_y, quat_z, incr_a, incr_b, incr_c,
                 input ready);
  modport sink(input valid, quat_w, quat_x, quat_y, quat_z, incr_a, incr_b, incr_c,
               output ready);
endinterface

interface qlu_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] res_w;
  logic [31:0] res_x;
  logic [31:0] res_y;
  logic [31:0] res_z;
  logic        incr_clamped;
  modport source(output valid, res_w, res_x, res_y, res_z, incr_clamped, input ready);
  modport sink(input valid, res_w, res_x, res_y, res_z, incr_clamped, output ready);
endinterface

interface qlu_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

FILE: sv/qlu_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a side payload.
`timescale 1ns / 1ps
module qlu_isqrt #(
  parameter int XW = qlu_pkg::SQ_W,
  parameter int SW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_vld,
  input  logic [XW-1:0]   x,
  input  logic [SW-1:0]   in_side,
  output logic            out_vld,
  output logic [XW/2-1:0] root,
  output logic [SW-1:0]   out_side
);
  localparam int NS = XW / 2;

  logic [XW-1:0] xr [0:NS];
  logic [XW-1:0] rr [0:NS];
  logic          vl [0:NS];
  logic [SW-1:0] sd [0:NS];

  assign xr[0] = x;
  assign rr[0] = '0;
  assign vl[0] = in_vld;
  assign sd[0] = in_side;

  for (genvar j = 0; j < NS; j++) begin : g_stage
    localparam logic [XW-1:0] BITV = XW'(1) << (XW - 2 - 2 * j);
    logic [XW-1:0] t;
    logic          ge;
    assign t  = rr[j] + BITV;
    assign ge = (xr[j] >= t);

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[j+1] <= 1'b0;
      end else if (en) begin
        vl[j+1] <= vl[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        xr[j+1] <= ge ? (xr[j] - t) : xr[j];
        rr[j+1] <= ge ? ((rr[j] >> 1) + BITV) : (rr[j] >> 1);
        sd[j+1] <= sd[j];
      end
    end
  end

  assign out_vld  = vl[NS];
  assign root     = rr[NS][NS-1:0];
  assign out_side = sd[NS];
endmodule

FILE: sv/qlu_div.sv
// Pipelined restoring divider, four lanes over one shared divisor, one quotient bit per stage.
`timescale 1ns / 1ps
module qlu_div #(
  parameter int DW = qlu_pkg::RT_W,
  parameter int QW = qlu_pkg::DQ_BITS + 1,
  parameter int SW = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [DW-1:0]            den,
  input  logic [3:0][DW+QW-1:0]    num,
  input  logic [SW-1:0]            in_side,
  output logic                     out_vld,
  output logic [3:0][QW-1:0]       quo,
  output logic [SW-1:0]            out_side
);
  // The numerator must stay below den * 2^QW, so its top part starts as a remainder.
  logic [3:0][DW-1:0] rm [0:QW];
  logic [3:0][QW-1:0] lo [0:QW];
  logic [DW-1:0]      dn [0:QW];
  logic               vl [0:QW];
  logic [SW-1:0]      sd [0:QW];

  for (genvar l = 0; l < 4; l++) begin : g_init
    assign rm[0][l] = num[l][DW+QW-1:QW];
    assign lo[0][l] = num[l][QW-1:0];
  end
  assign dn[0] = den;
  assign vl[0] = in_vld;
  assign sd[0] = in_side;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [3:0][DW:0]   t;
    logic [3:0]         ge;
    logic [3:0][DW-1:0] nrem;
    logic [3:0][QW-1:0] nlo;

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        t[l]    = {rm[j][l], lo[j][l][QW-1]};
        ge[l]   = (t[l] >= {1'b0, dn[j]});
        nrem[l] = ge[l] ? DW'(t[l] - {1'b0, dn[j]}) : t[l][DW-1:0];
        nlo[l]  = {lo[j][l][QW-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[j+1] <= 1'b0;
      end else if (en) begin
        vl[j+1] <= vl[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rm[j+1] <= nrem;
        lo[j+1] <= nlo;
        dn[j+1] <= dn[j];
        sd[j+1] <= sd[j];
      end
    end
  end

  assign out_vld  = vl[QW];
  assign quo      = lo[QW];
  assign out_side = sd[QW];
endmodule

FILE: sv/quaternion_local_update.sv
// Top level of the quaternion local update: increment to delta quaternion, product, renormalize.
//
//   channel | direction | beat contents
//   --------+-----------+-----------------------------------------------------
//   req     | in        | quat_w, quat_x, quat_y, quat_z, incr_a, incr_b, incr_c
//   rsp     | out       | res_w, res_x, res_y, res_z, incr_clamped
//   cfg     | in        | data (yaw_only_mode), always ready
//
// One beat enters per cycle and one result leaves per cycle while no result is held back;
// the pipeline depth is set by the three 32-stage square root pipelines and the two
// restoring dividers (31 and FRAC_BITS + 1 stages).
// Reset is synchronous and clears only valid bits and the mode register.
// The whole pipeline moves together; it freezes only when the result register holds an
// unaccepted beat and the stage before it is full, so nothing is lost or repeated.
`timescale 1ns / 1ps
module quaternion_local_update #(
  parameter int FRAC_BITS = qlu_pkg::FRAC_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  qlu_req_if.sink    req,
  qlu_rsp_if.source  rsp,
  qlu_cfg_if.sink    cfg
);
  localparam int MW  = qlu_pkg::M_W;
  localparam int RW  = qlu_pkg::RT_W;
  localparam int QWA = qlu_pkg::DQ_BITS + 1;
  localparam int NWA = RW + QWA;
  localparam int QWC = FRAC_BITS + 1;
  localparam int NWC = RW + QWC;
  localparam qlu_pkg::dword_t ONE2  = qlu_pkg::dword_t'(1) << (2 * FRAC_BITS);
  localparam qlu_pkg::dword_t FOUR2 = ONE2 << 2;

  // Fields that ride along the whole pipeline: the input quaternion for the zero-increment
  // bypass, and the two flags.
  typedef struct packed {
    logic [3:0][31:0] q;
    logic             cl;
    logic             zr;
  } ct_t;
  typedef struct packed {
    ct_t              c;
    logic [2:0][31:0] v;
  } sa_t;
  typedef struct packed {
    ct_t              c;
    logic [3:0][MW-1:0] m;
    logic [3:0]       ng;
  } sb_t;
  typedef struct packed {
    ct_t        c;
    logic [3:0] ng;
  } sc_t;
  typedef struct packed {
    sb_t  b;
    logic mz;
  } sd_t;
  typedef struct packed {
    sc_t  s;
    logic mz;
  } se_t;

  logic en;
  logic en_out;
  logic yaw;

  // Configuration register.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      yaw <= 1'b0;
    end else if (cfg.valid) begin
      yaw <= cfg.data;
    end
  end

  // Stage registers.
  logic vd1, vd2, vd3, vd4, vd5, vd6, vd7, vd8, vd9, vd10, vd11, vd12;
  logic vd13, vd14, vd15, vd16, vd17, vd18, vd19, vd20;
  ct_t  c1, c2, c3, c4;
  logic [2:0][31:0] v1, v2, v3;
  logic [2:0][63:0] sq2;
  logic [63:0]      s3, x4;
  sa_t  sa4;

  logic             vdA;
  logic [RW-1:0]    rootA;
  sa_t              saA;

  sb_t              sb5, sb6, sb7;
  logic [3:0][63:0] sq6;
  logic [63:0]      s7;

  logic             vdB;
  logic [RW-1:0]    rootB;
  sb_t              sbB;

  logic [3:0][NWA-1:0] numA;
  logic [RW-1:0]       denA;
  sc_t                 sc8;

  logic                vdDA;
  logic [3:0][QWA-1:0] quoA;
  sc_t                 scDA;

  logic [3:0][31:0]      d9;
  ct_t                   c9, c10, c11, c12, c13, c14, c15, c16, c17, c18, c19;
  logic [3:0][3:0][63:0] pr10;
  logic [3:0][1:0][63:0] h11;
  logic [3:0][63:0]      p12, m13, m14, m15, m16;
  logic [3:0]            ng13, ng14, ng15, ng16, ng17, ng18, ng19;
  logic [63:0]           mxa14, mxb14, mx15;
  logic [5:0]            sh16;
  logic                  mz16, mz17, mz18, mz19;
  logic [3:0][MW-1:0]    m17, m18, m19;
  logic [3:0][63:0]      sq18;
  logic [63:0]           s19;

  logic                  vdC;
  logic [RW-1:0]         rootC;
  sd_t                   sdC;

  logic [3:0][NWC-1:0]   numC;
  logic [RW-1:0]         denC;
  se_t                   se20;

  logic                  vdDC;
  logic [3:0][QWC-1:0]   quoC;
  se_t                   seDC;

  // Combinational helpers between stages.
  logic [3:0][31:0] mg5;
  logic             sh5;
  logic [6:0]       bl16;

  always_comb begin
    mg5[0] = rootA;
    for (int i = 0; i < 3; i++) begin
      mg5[i+1] = saA.v[i][31] ? (~saA.v[i] + 32'd1) : saA.v[i];
    end
    sh5 = mg5[0][31] | mg5[1][31] | mg5[2][31] | mg5[3][31];
  end

  // Bit length of the largest product magnitude.
  always_comb begin
    bl16 = '0;
    for (int b = 0; b < 64; b++) begin
      if (mx15[b]) begin
        bl16 = 7'(b + 1);
      end
    end
  end

  assign en_out    = !rsp.valid || rsp.ready;
  assign en        = en_out || !vdDC;
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      {vd1, vd2, vd3, vd4, vd5, vd6, vd7, vd8, vd9, vd10} <= '0;
      {vd11, vd12, vd13, vd14, vd15, vd16, vd17, vd18, vd19, vd20} <= '0;
    end else if (en) begin
      vd1  <= req.valid;
      vd2  <= vd1;
      vd3  <= vd2;
      vd4  <= vd3;
      vd5  <= vdA;
      vd6  <= vd5;
      vd7  <= vd6;
      vd8  <= vdB;
      vd9  <= vdDA;
      vd10 <= vd9;
      vd11 <= vd10;
      vd12 <= vd11;
      vd13 <= vd12;
      vd14 <= vd13;
      vd15 <= vd14;
      vd16 <= vd15;
      vd17 <= vd16;
      vd18 <= vd17;
      vd19 <= vd18;
      vd20 <= vdC;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Capture; in yaw mode the first component becomes a rotation about z.
      c1.q  <= {req.quat_z, req.quat_y, req.quat_x, req.quat_w};
      c1.cl <= 1'b0;
      c1.zr <= 1'b0;
      v1    <= yaw ? {req.incr_a, 32'd0, 32'd0} : {req.incr_c, req.incr_b, req.incr_a};

      // Squares of the increment.
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= qlu_pkg::smul(v1[i], v1[i]);
      end
      c2 <= c1;
      v2 <= v1;

      s3 <= sq2[0] + sq2[1] + sq2[2];
      c3 <= c2;
      v3 <= v2;

      // Clamp the squared norm and form the radicand of twice the scalar part.
      c4.q    <= c3.q;
      c4.cl   <= (s3 > ONE2);
      c4.zr   <= (s3 == '0);
      x4      <= FOUR2 - ((s3 > ONE2) ? ONE2 : s3);

      // Magnitudes of the unnormalized delta, brought below 2^31 together.
      sb5.c <= saA.c;
      for (int j = 0; j < 4; j++) begin
        sb5.m[j] <= sh5 ? mg5[j][31:1] : mg5[j][30:0];
      end
      sb5.ng <= {saA.v[2][31], saA.v[1][31], saA.v[0][31], 1'b0};

      for (int j = 0; j < 4; j++) begin
        sq6[j] <= 64'(sb5.m[j]) * 64'(sb5.m[j]);
      end
      sb6 <= sb5;

      s7  <= sq6[0] + sq6[1] + sq6[2] + sq6[3];
      sb7 <= sb6;

      // Rounded quotient numerators for the delta.
      for (int j = 0; j < 4; j++) begin
        numA[j] <= (NWA'(sbB.m[j]) << qlu_pkg::DQ_BITS) + NWA'(rootB >> 1);
      end
      denA    <= rootB;
      sc8.c   <= sbB.c;
      sc8.ng  <= sbB.ng;

      // Signed delta quaternion.
      for (int j = 0; j < 4; j++) begin
        d9[j] <= scDA.ng[j] ? (~32'(quoA[j]) + 32'd1) : 32'(quoA[j]);
      end
      c9 <= scDA.c;

      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          pr10[i][j] <= qlu_pkg::smul(d9[i], c9.q[j]);
        end
      end
      c10 <= c9;

      // Hamilton product delta * q, in pairs of terms.
      h11[0][0] <= pr10[0][0] - pr10[1][1];
      h11[0][1] <= pr10[2][2] + pr10[3][3];
      h11[1][0] <= pr10[0][1] + pr10[1][0];
      h11[1][1] <= pr10[2][3] - pr10[3][2];
      h11[2][0] <= pr10[0][2] - pr10[1][3];
      h11[2][1] <= pr10[2][0] + pr10[3][1];
      h11[3][0] <= pr10[0][3] + pr10[1][2];
      h11[3][1] <= pr10[3][0] - pr10[2][1];
      c11 <= c10;

      p12[0] <= h11[0][0] - h11[0][1];
      for (int i = 1; i < 4; i++) begin
        p12[i] <= h11[i][0] + h11[i][1];
      end
      c12 <= c11;

      // Sign flip for a negative scalar part folds into the component signs.
      for (int i = 0; i < 4; i++) begin
        m13[i]  <= p12[i][63] ? (~p12[i] + 64'd1) : p12[i];
        ng13[i] <= p12[i][63] ^ p12[0][63];
      end
      c13 <= c12;

      mxa14 <= (m13[0] > m13[1]) ? m13[0] : m13[1];
      mxb14 <= (m13[2] > m13[3]) ? m13[2] : m13[3];
      m14   <= m13;
      ng14  <= ng13;
      c14   <= c13;

      mx15 <= (mxa14 > mxb14) ? mxa14 : mxb14;
      m15  <= m14;
      ng15 <= ng14;
      c15  <= c14;

      sh16 <= (bl16 > 7'd31) ? 6'(bl16 - 7'd31) : 6'd0;
      mz16 <= (mx15 == '0);
      m16  <= m15;
      ng16 <= ng15;
      c16  <= c15;

      for (int j = 0; j < 4; j++) begin
        m17[j] <= MW'(m16[j] >> sh16);
      end
      mz17 <= mz16;
      ng17 <= ng16;
      c17  <= c16;

      for (int j = 0; j < 4; j++) begin
        sq18[j] <= 64'(m17[j]) * 64'(m17[j]);
      end
      m18  <= m17;
      mz18 <= mz17;
      ng18 <= ng17;
      c18  <= c17;

      s19  <= sq18[0] + sq18[1] + sq18[2] + sq18[3];
      m19  <= m18;
      mz19 <= mz18;
      ng19 <= ng18;
      c19  <= c18;

      // Rounded quotient numerators for the result.
      for (int j = 0; j < 4; j++) begin
        numC[j] <= (NWC'(sdC.b.m[j]) << FRAC_BITS) + NWC'(rootC >> 1);
      end
      denC       <= rootC;
      se20.s.c   <= sdC.b.c;
      se20.s.ng  <= sdC.b.ng;
      se20.mz    <= sdC.mz;
    end
  end

  // v3 belongs to the stage before c4, so the increment is kept aligned by its own register.
  logic [2:0][31:0] v4;
  always_ff @(posedge clk) begin
    if (en) begin
      v4 <= v3;
    end
  end

  assign sa4 = '{c: c4, v: v4};

  qlu_isqrt #(.XW(qlu_pkg::SQ_W), .SW($bits(sa_t))) u_sqrt_a (
    .clk(clk), .rst(rst), .en(en), .in_vld(vd4), .x(x4),
    .in_side(sa4), .out_vld(vdA), .root(rootA), .out_side(saA)
  );

  qlu_isqrt #(.XW(qlu_pkg::SQ_W), .SW($bits(sb_t))) u_sqrt_b (
    .clk(clk), .rst(rst), .en(en), .in_vld(vd7), .x(s7),
    .in_side(sb7), .out_vld(vdB), .root(rootB), .out_side(sbB)
  );

  qlu_div #(.DW(RW), .QW(QWA), .SW($bits(sc_t))) u_div_a (
    .clk(clk), .rst(rst), .en(en), .in_vld(vd8), .den(denA), .num(numA),
    .in_side(sc8), .out_vld(vdDA), .quo(quoA), .out_side(scDA)
  );

  qlu_isqrt #(.XW(qlu_pkg::SQ_W), .SW($bits(sd_t))) u_sqrt_c (
    .clk(clk), .rst(rst), .en(en), .in_vld(vd19), .x(s19),
    .in_side({c19, m19, ng19, mz19}), .out_vld(vdC), .root(rootC), .out_side(sdC)
  );

  qlu_div #(.DW(RW), .QW(QWC), .SW($bits(se_t))) u_div_c (
    .clk(clk), .rst(rst), .en(en), .in_vld(vd20), .den(denC), .num(numC),
    .in_side(se20), .out_vld(vdDC), .quo(quoC), .out_side(seDC)
  );

  // Result register: bypass for a zero increment, zero for a zero product, else the
  // signed quotients.
  logic [3:0][31:0] res;
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (seDC.s.c.zr) begin
        res[i] = seDC.s.c.q[i];
      end else if (seDC.mz) begin
        res[i] = '0;
      end else begin
        res[i] = seDC.s.ng[i] ? (~32'(64'(quoC[i])) + 32'd1) : 32'(64'(quoC[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (en_out) begin
      rsp.valid <= vdDC;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out && vdDC) begin
      rsp.res_w        <= res[0];
      rsp.res_x        <= res[1];
      rsp.res_y        <= res[2];
      rsp.res_z        <= res[3];
      rsp.incr_clamped <= seDC.s.c.cl;
    end
  end

  // The request side only waits behind a result that is being held back.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> (rsp.valid && !rsp.ready))
    else $error("request stalled without a held result");

  // A frozen pipeline keeps its last beat.
  a_keep_last: assert property (@(posedge clk) disable iff (rst)
    (vdDC && !en) |=> vdDC)
    else $error("beat lost during a stall");

  // A clamped increment never takes the bypass, so the scalar part is nonnegative.
  a_clamp_sign: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.incr_clamped) |-> !rsp.res_w[31])
    else $error("negative scalar part after a clamped update");

endmodule

FILE: sim/qlu_checker.sv
// Result checker for the quaternion local update: watches channels, predicts, compares.
`timescale 1ns / 1ps
module qlu_checker (
  input  logic       clk,
  input  logic       rst,
  qlu_req_if.sink    req_mon,
  qlu_rsp_if.sink    rsp_mon,
  qlu_cfg_if.sink    cfg_mon,
  output int         fail_count,
  output int         pending,
  output int         result_count,
  output int         clamp_count
);
  typedef struct packed {
    logic [31:0] w;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        clamped;
  } quat_res_t;

  quat_res_t expected_quats[$];
  logic      yaw_mode;

  function automatic logic [63:0] int_sqrt(input logic [63:0] val);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > val) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (val >= root + bitv) begin
        val = val - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // Scales a 4-vector to unit length with fbits fraction bits; zero stays zero.
  function automatic void unit_vec(input longint vin [4], input int fbits,
                                   output longint vout [4]);
    logic [63:0] mag [4];
    logic [63:0] mx;
    logic [63:0] sumsq;
    logic [63:0] nrm;
    logic [63:0] qt;
    int sh;
    mx = 0;
    sumsq = 0;
    sh = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = vin[i] < 0 ? 64'(-vin[i]) : 64'(vin[i]);
      if (mag[i] > mx) mx = mag[i];
    end
    if (mx == 0) begin
      vout = vin;
      return;
    end
    while ((mx >> 31) != 0) begin
      mx = mx >> 1;
      sh++;
    end
    for (int i = 0; i < 4; i++) begin
      mag[i] = mag[i] >> sh;
      sumsq += mag[i] * mag[i];
    end
    nrm = int_sqrt(sumsq);
    for (int i = 0; i < 4; i++) begin
      qt = ((mag[i] << fbits) + (nrm >> 1)) / nrm;
      vout[i] = vin[i] < 0 ? -longint'(qt) : longint'(qt);
    end
  endfunction

  function automatic quat_res_t rotate_quat(input logic [31:0] qw, qx, qy, qz,
                                            input logic [31:0] ia, ib, ic,
                                            input logic yaw);
    longint q [4];
    longint v [3];
    longint d0 [4];
    longint d [4];
    longint p [4];
    longint r [4];
    logic [63:0] s;
    logic [63:0] one2;
    quat_res_t res;
    q[0] = longint'($signed(qw));
    q[1] = longint'($signed(qx));
    q[2] = longint'($signed(qy));
    q[3] = longint'($signed(qz));
    if (yaw) begin
      v[0] = 0;
      v[1] = 0;
      v[2] = longint'($signed(ia));
    end else begin
      v[0] = longint'($signed(ia));
      v[1] = longint'($signed(ib));
      v[2] = longint'($signed(ic));
    end
    s = 0;
    for (int i = 0; i < 3; i++) s += 64'(v[i] * v[i]);
    if (s == 0) begin
      res = '{qw, qx, qy, qz, 1'b0};
      return res;
    end
    one2 = 64'd1 << (2 * qlu_pkg::FRAC_BITS_DEF);
    res.clamped = s > one2;
    if (res.clamped) s = one2;
    d0[0] = longint'(int_sqrt(4 * one2 - s));
    d0[1] = v[0];
    d0[2] = v[1];
    d0[3] = v[2];
    unit_vec(d0, qlu_pkg::DQ_BITS, d);
    p[0] = d[0] * q[0] - d[1] * q[1] - d[2] * q[2] - d[3] * q[3];
    p[1] = d[0] * q[1] + d[1] * q[0] + d[2] * q[3] - d[3] * q[2];
    p[2] = d[0] * q[2] - d[1] * q[3] + d[2] * q[0] + d[3] * q[1];
    p[3] = d[0] * q[3] + d[1] * q[2] - d[2] * q[1] + d[3] * q[0];
    if (p[0] < 0) for (int i = 0; i < 4; i++) p[i] = -p[i];
    unit_vec(p, qlu_pkg::FRAC_BITS_DEF, r);
    res.w = r[0][31:0];
    res.x = r[1][31:0];
    res.y = r[2][31:0];
    res.z = r[3][31:0];
    return res;
  endfunction

  always @(posedge clk) begin
    quat_res_t got;
    quat_res_t want;
    if (rst) begin
      yaw_mode <= 1'b0;
      fail_count <= 0;
      result_count <= 0;
      clamp_count <= 0;
      pending <= 0;
      expected_quats.delete();
    end else begin
      if (req_mon.valid && req_mon.ready)
        expected_quats.push_back(rotate_quat(req_mon.quat_w, req_mon.quat_x, req_mon.quat_y,
                                             req_mon.quat_z, req_mon.incr_a, req_mon.incr_b,
                                             req_mon.incr_c, yaw_mode));
      if (cfg_mon.valid && cfg_mon.ready) yaw_mode <= cfg_mon.data;
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = '{rsp_mon.res_w, rsp_mon.res_x, rsp_mon.res_y, rsp_mon.res_z,
                rsp_mon.incr_clamped};
        result_count <= result_count + 1;
        if (got.clamped) clamp_count <= clamp_count + 1;
        if (expected_quats.size() == 0) begin
          if (fail_count < 10) $display("checker: unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_quats.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display({"checker: mismatch exp w=%h x=%h y=%h z=%h c=%b",
                        " got w=%h x=%h y=%h z=%h c=%b"},
                       want.w, want.x, want.y, want.z, want.clamped,
                       got.w, got.x, got.y, got.z, got.clamped);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_quats.size();
    end
  end
endmodule

FILE: sim/testbench.sv
// Testbench top for the quaternion local update: stimulus, flow control and verdict.
`timescale 1ns / 1ps
module testbench;

  // Latency of the block at the default fraction width.
  localparam int LATENCY   = 149 + qlu_pkg::FRAC_BITS_DEF;
  localparam int ONE       = 32'h4000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  qlu_req_if req ();
  qlu_rsp_if rsp ();
  qlu_cfg_if cfg ();

  int fail_count;
  int pending;
  int result_count;
  int clamp_count;

  // Idle percentages of the sender and of the receiver for the current phase.
  int send_idle = 0;
  int recv_idle = 0;
  // When set, the receiver holds ready low for a counted stretch of cycles.
  bit hold_off = 1'b0;
  int items_sent = 0;

  always #5 clk = ~clk;

  quaternion_local_update dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  qlu_checker chk (.clk(clk), .rst(rst), .req_mon(req), .rsp_mon(rsp), .cfg_mon(cfg),
                   .fail_count(fail_count), .pending(pending),
                   .result_count(result_count), .clamp_count(clamp_count));

  // The receiver draws its stall decision fresh every cycle; a hold-off overrides it.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
    end
  end

  // Offers one beat and waits until it is accepted, idling first at random.
  task automatic send_beat(input logic [31:0] w, x, y, z, a, b, c);
    while ($urandom_range(99) < send_idle) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.quat_w <= w;
    req.quat_x <= x;
    req.quat_y <= y;
    req.quat_z <= z;
    req.incr_a <= a;
    req.incr_b <= b;
    req.incr_c <= c;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    items_sent++;
  endtask

  // Waits for the pipeline to drain, then lets the latency pass before a register write.
  task automatic drain();
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    drain();
    cfg.valid <= 1'b1;
    cfg.data  <= mode;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Random word in Q2.30 of a chosen scale: small, around unit range, or any value.
  function automatic logic [31:0] rand_word(input int kind);
    case (kind)
      0: begin
        return 32'($signed($urandom_range(2 * ONE)) - ONE);
      end
      1: begin
        return 32'($signed($urandom_range(1 << 22)) - (1 << 21));
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // Mostly quaternion components within unit range with modest increments; some full-range noise.
  task automatic send_random(input int count);
    logic [31:0] w, x, y, z;
    int ik;
    int qk;
    for (int n = 0; n < count; n++) begin
      qk = ($urandom_range(9) == 0) ? 2 : 0;
      ik = $urandom_range(9) < 6 ? 1 : ($urandom_range(3) == 0 ? 2 : 0);
      w = rand_word(qk);
      x = rand_word(qk);
      y = rand_word(qk);
      z = rand_word(qk);
      if ($urandom_range(19) == 0) begin
        send_beat(w, x, y, z, 0, 0, 0);
      end else begin
        send_beat(w, x, y, z, rand_word(ik), rand_word(ik), rand_word(ik));
      end
    end
  endtask

  task automatic run_directed();
    send_beat(ONE, 0, 0, 0, 0, 0, 0);
    send_beat(32'h1234_5678, 32'h8000_0000, 32'h7fff_ffff, 32'hdead_beef, 0, 0, 0);
    send_beat(ONE, 0, 0, 0, 32'h0010_0000, 0, 0);
    send_beat(ONE, 0, 0, 0, 0, 32'h0010_0000, 0);
    send_beat(ONE, 0, 0, 0, 0, 0, 32'hfff0_0000);
    send_beat(ONE, 0, 0, 0, ONE, 0, 0);
    send_beat(ONE, 0, 0, 0, ONE, 1, 0);
    send_beat(ONE, 0, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_beat(ONE, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_beat(0, 0, 0, 0, 32'h0100_0000, 0, 0);
    send_beat(32'hc000_0000, 0, 0, ONE, 32'h0100_0000, 0, 0);
    send_beat(0, ONE, 0, 0, 0, 0, ONE);
    send_beat(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1, 1, 1);
    send_beat(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'hffff_ffff, 0, 0);
    send_beat(ONE, 0, 0, 0, 1, 0, 0);
    send_beat(32'h2000_0000, 32'h2000_0000, 32'h2000_0000, 32'h2000_0000,
              32'h5555_5555, 32'haaaa_aaaa, 32'h3333_3333);
  endtask

  initial begin
    req.valid <= 1'b0;
    req.quat_w <= '0;
    req.quat_x <= '0;
    req.quat_y <= '0;
    req.quat_z <= '0;
    req.incr_a <= '0;
    req.incr_b <= '0;
    req.incr_c <= '0;
    cfg.valid <= 1'b0;
    cfg.data <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full increments, no idling, with directed corners first.
    write_mode(1'b0);
    run_directed();
    send_random(300);

    // Yaw-only mode; the directed beats check that only the first increment counts.
    send_idle = 47;
    write_mode(1'b1);
    run_directed();
    send_random(250);

    // Receiver holds off for a long stretch while the sender keeps offering beats.
    send_idle = 0;
    recv_idle = 0;
    fork
      begin
        hold_off = 1'b1;
        repeat (3 * LATENCY) @(posedge clk);
        hold_off = 1'b0;
      end
      send_random(2 * LATENCY);
    join

    // Sender pauses until every expected result is back.
    req.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    recv_idle = 47;
    send_random(250);

    write_mode(1'b0);
    send_idle = 27;
    recv_idle = 27;
    send_random(300);
    send_idle = 0;
    recv_idle = 47;
    send_random(300);

    write_mode(1'b1);
    send_idle = 47;
    recv_idle = 0;
    send_random(100);

    drain();
    $display("testbench: %0d beats sent, %0d results checked, %0d clamped increments",
             items_sent, result_count, clamp_count);
    $display("testbench: both modes, corner values, zero increments, stalls and back-pressure");
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Guards against a hung handshake.
  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end
endmodule
